// ===== rtl/pslim_pkg.sv =====
// Shared types, constants and register codes of the PID speed slew limiter.
`default_nettype none

package pslim_pkg;

	localparam int MAX_SPEED_UNITS_DEF = 1024;
	localparam int NUM_MOTORS          = 2;

	// pipeline depth from input register to result register
	localparam int PIPE_DEPTH = 10;

	// divider numerator and quotient widths
	localparam int NUM_W = 30;
	localparam int QUO_W = 15;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		CFG_GAIN_PROP   = 2'd0,
		CFG_GAIN_INTEG  = 2'd1,
		CFG_GAIN_DERIV  = 2'd2,
		CFG_ACCEL_LIMIT = 2'd3
	} cfg_addr_t;

	// PWM prescaler choice
	typedef enum logic [1:0] {
		FREQ_KEEP    = 2'd0,
		FREQ_DIV1024 = 2'd1,
		FREQ_DIV256  = 2'd2,
		FREQ_DIV64   = 2'd3
	} freq_sel_t;

	localparam logic [15:0] GAIN_PROP_RESET = 16'd256;
	localparam logic [14:0] ACCEL_RESET     = 15'd2458;
	localparam logic [14:0] ACCEL_MAX       = 15'd16384;

	localparam logic signed [15:0] DUTY_INIT0    = 16'sd3277;
	localparam logic [15:0]        DUTY_OPEN_MAX = 16'd32767;

	// prescaler thresholds on the smaller absolute duty, Q2.14
	localparam logic [16:0] THR_LOW  = 17'd1311;
	localparam logic [16:0] THR_MID  = 17'd4916;
	localparam logic [16:0] THR_HIGH = 17'd8192;

	typedef struct packed {
		logic [15:0] gain_prop;
		logic [15:0] gain_integ;
		logic [15:0] gain_deriv;
		logic [14:0] accel_limit;
	} cfg_t;

	// error terms leaving the front end
	typedef struct packed {
		logic               motor;
		logic               engage;
		logic [15:0]        ref_speed;
		logic signed [16:0] err;
		logic signed [31:0] err_sum;
		logic signed [17:0] err_diff;
	} err_item_t;

	// divider numerator with saturation and sign
	typedef struct packed {
		logic             motor;
		logic             engage;
		logic             sat;
		logic             neg;
		logic [NUM_W-1:0] num;
	} mac_item_t;

	// correction or open-loop duty magnitude
	typedef struct packed {
		logic        motor;
		logic        engage;
		logic        neg;
		logic [15:0] mag;
	} div_item_t;

	// one result
	typedef struct packed {
		logic               motor;
		logic signed [15:0] duty;
		freq_sel_t          freq;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/pslim_err.sv =====
// Input register, error, saturating integral and derivative per motor.
`default_nettype none

module pslim_err (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  motor_sel,
	input  logic                  closed_loop,
	input  logic [15:0]           ref_speed,
	input  logic [15:0]           curr_speed,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pslim_pkg::err_item_t  out_item
);
	import pslim_pkg::*;

	logic v_s1, v_s2;
	logic en_s1, en_s2;

	logic        motor_s1;
	logic        engage_s1;
	logic [15:0] ref_s1;
	logic [15:0] cur_s1;
	err_item_t   item_s2;

	logic signed [31:0] err_sum_q  [NUM_MOTORS];
	logic signed [16:0] prev_err_q [NUM_MOTORS];

	logic signed [16:0] err;
	logic signed [32:0] sum_wide;
	logic signed [31:0] sum_sat;
	logic signed [17:0] diff;

	// a stage loads when empty or when its content moves on
	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1)
				v_s1 <= in_valid;
			if (en_s2)
				v_s2 <= v_s1;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en_s1) begin
			motor_s1  <= motor_sel;
			engage_s1 <= closed_loop;
			ref_s1    <= ref_speed;
			cur_s1    <= curr_speed;
		end
	end

	// signed error, integral with saturation, difference to last error
	always_comb begin
		err      = signed'({1'b0, ref_s1}) - signed'({1'b0, cur_s1});
		sum_wide = 33'(err_sum_q[motor_s1]) + 33'(err);
		if (sum_wide[32] != sum_wide[31])
			sum_sat = sum_wide[32] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
		else
			sum_sat = sum_wide[31:0];
		diff = 18'(err) - 18'(prev_err_q[motor_s1]);
	end

	// per-motor loop state, touched only by engaged requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				err_sum_q[i]  <= '0;
				prev_err_q[i] <= '0;
			end
		end else if (en_s2 && v_s1 && engage_s1) begin
			err_sum_q[motor_s1]  <= sum_sat;
			prev_err_q[motor_s1] <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			item_s2.motor     <= motor_s1;
			item_s2.engage    <= engage_s1;
			item_s2.ref_speed <= ref_s1;
			item_s2.err       <= err;
			item_s2.err_sum   <= sum_sat;
			item_s2.err_diff  <= diff;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

endmodule

`default_nettype wire

// ===== rtl/pslim_mac.sv =====
// Gain products, their sum, and the saturation test ahead of the divider.
`default_nettype none

module pslim_mac #(
	parameter int MAX_SPEED_UNITS = pslim_pkg::MAX_SPEED_UNITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pslim_pkg::cfg_t       cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pslim_pkg::err_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pslim_pkg::mac_item_t  out_item
);
	import pslim_pkg::*;

	localparam logic [15:0] DIV      = 16'(MAX_SPEED_UNITS);
	// open-loop quotient exceeds full scale at or above this numerator
	localparam logic [53:0] OPEN_LIM = 54'(64'd32768 * MAX_SPEED_UNITS);

	logic v_s3, v_s4, v_s5;
	logic en_s3, en_s4, en_s5;

	logic               motor_s3, engage_s3;
	logic [15:0]        ref_s3;
	logic signed [33:0] p_prop_s3;
	logic signed [48:0] p_int_s3;
	logic signed [34:0] p_der_s3;
	logic [30:0]        lim_s3;

	logic               motor_s4, engage_s4;
	logic [15:0]        ref_s4;
	logic signed [49:0] sum_s4;
	logic [30:0]        lim_s4;

	mac_item_t item_s5;

	logic signed [16:0] gp, gi, gd;
	logic [49:0]        mag;
	logic [53:0]        num_full;
	logic [NUM_W-1:0]   num_open;
	logic               sat_closed, sat_open;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s3)
				v_s3 <= in_valid;
			if (en_s4)
				v_s4 <= v_s3;
			if (en_s5)
				v_s5 <= v_s4;
		end
	end

	// Q7.9 gains as non-negative signed operands
	assign gp = signed'({1'b0, cfg.gain_prop});
	assign gi = signed'({1'b0, cfg.gain_integ});
	assign gd = signed'({1'b0, cfg.gain_deriv});

	// three gain products and the accel bound scaled by the divisor
	always_ff @(posedge clk) begin
		if (en_s3) begin
			motor_s3  <= in_item.motor;
			engage_s3 <= in_item.engage;
			ref_s3    <= in_item.ref_speed;
			p_prop_s3 <= 34'(gp) * 34'(in_item.err);
			p_int_s3  <= 49'(gi) * 49'(in_item.err_sum);
			p_der_s3  <= 35'(gd) * 35'(in_item.err_diff);
			lim_s3    <= 31'(cfg.accel_limit) * 31'(DIV);
		end
	end

	// PID sum
	always_ff @(posedge clk) begin
		if (en_s4) begin
			motor_s4  <= motor_s3;
			engage_s4 <= engage_s3;
			ref_s4    <= ref_s3;
			sum_s4    <= 50'(p_prop_s3) + 50'(p_int_s3) + 50'(p_der_s3);
			lim_s4    <= lim_s3;
		end
	end

	// magnitude times 32; a quotient at or past its bound needs no division
	always_comb begin
		mag        = sum_s4[49] ? 50'(-sum_s4) : 50'(sum_s4);
		num_full   = {mag[48:0], 5'b00000};
		num_open   = {ref_s4, 14'b0};
		sat_closed = num_full >= 54'(lim_s4);
		sat_open   = 54'(num_open) >= OPEN_LIM;
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			item_s5.motor  <= motor_s4;
			item_s5.engage <= engage_s4;
			item_s5.neg    <= sum_s4[49];
			item_s5.sat    <= engage_s4 ? sat_closed : sat_open;
			item_s5.num    <= engage_s4 ? num_full[NUM_W-1:0] : num_open;
		end
	end

	assign out_valid = v_s5;
	assign out_item  = item_s5;

endmodule

`default_nettype wire

// ===== rtl/pslim_div.sv =====
// Division by the speed scale through a reciprocal multiply and one correction.
`default_nettype none

module pslim_div #(
	parameter int MAX_SPEED_UNITS = pslim_pkg::MAX_SPEED_UNITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [14:0]           accel_limit,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pslim_pkg::mac_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pslim_pkg::div_item_t  out_item
);
	import pslim_pkg::*;

	localparam int          HALF_W = NUM_W / 2;
	localparam logic [15:0] DIV    = 16'(MAX_SPEED_UNITS);
	// floor(2^NUM_W / divisor): estimate is exact or one low
	localparam logic [NUM_W:0] RECIP = (NUM_W + 1)'((64'd1 << NUM_W) / MAX_SPEED_UNITS);

	logic v_s6, v_s7, v_s8, v_s9;
	logic en_s6, en_s7, en_s8, en_s9;

	mac_item_t                item_s6;
	logic [HALF_W+NUM_W:0]    pp_hi_s6, pp_lo_s6;
	mac_item_t                item_s7;
	logic [QUO_W-1:0]         q0_s7;
	mac_item_t                item_s8;
	logic [QUO_W-1:0]         q0_s8;
	logic [NUM_W:0]           qd_s8;
	div_item_t                item_s9;

	logic [HALF_W+2*NUM_W:0]  total;
	logic [NUM_W+1:0]         rem;
	logic                     bump;
	logic [15:0]              quo;
	logic [15:0]              mag;

	assign en_s9    = !v_s9 || out_ready;
	assign en_s8    = !v_s8 || en_s9;
	assign en_s7    = !v_s7 || en_s8;
	assign en_s6    = !v_s6 || en_s7;
	assign in_ready = en_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en_s6)
				v_s6 <= in_valid;
			if (en_s7)
				v_s7 <= v_s6;
			if (en_s8)
				v_s8 <= v_s7;
			if (en_s9)
				v_s9 <= v_s8;
		end
	end

	// numerator halves times the reciprocal
	always_ff @(posedge clk) begin
		if (en_s6) begin
			item_s6  <= in_item;
			pp_hi_s6 <= (HALF_W + NUM_W + 1)'(in_item.num[NUM_W-1:HALF_W]) *
			            (HALF_W + NUM_W + 1)'(RECIP);
			pp_lo_s6 <= (HALF_W + NUM_W + 1)'(in_item.num[HALF_W-1:0]) *
			            (HALF_W + NUM_W + 1)'(RECIP);
		end
	end

	// recombine and take the quotient estimate
	assign total = {pp_hi_s6, {HALF_W{1'b0}}} + (HALF_W + 2 * NUM_W + 1)'(pp_lo_s6);

	always_ff @(posedge clk) begin
		if (en_s7) begin
			item_s7 <= item_s6;
			q0_s7   <= total[NUM_W+QUO_W-1:NUM_W];
		end
	end

	// estimate times divisor for the remainder check
	always_ff @(posedge clk) begin
		if (en_s8) begin
			item_s8 <= item_s7;
			q0_s8   <= q0_s7;
			qd_s8   <= (NUM_W + 1)'(q0_s7) * (NUM_W + 1)'(DIV);
		end
	end

	// one compare and bump; saturated requests take their bound
	always_comb begin
		rem  = (NUM_W + 2)'(item_s8.num) - (NUM_W + 2)'(qd_s8);
		bump = !rem[NUM_W+1] && (rem >= (NUM_W + 2)'(DIV));
		quo  = 16'(q0_s8) + 16'(bump);
		if (item_s8.sat)
			mag = item_s8.engage ? {1'b0, accel_limit} : DUTY_OPEN_MAX;
		else
			mag = quo;
	end

	always_ff @(posedge clk) begin
		if (en_s9) begin
			item_s9.motor  <= item_s8.motor;
			item_s9.engage <= item_s8.engage;
			item_s9.neg    <= item_s8.neg;
			item_s9.mag    <= mag;
		end
	end

	assign out_valid = v_s9;
	assign out_item  = item_s9;

endmodule

`default_nettype wire

// ===== rtl/pslim_duty.sv =====
// Held duty update, applied duty per motor, prescaler choice and result register.
`default_nettype none

module pslim_duty (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pslim_pkg::div_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pslim_pkg::res_t       out_res
);
	import pslim_pkg::*;

	logic en_s10;
	logic v_s10;
	res_t res_s10;

	logic signed [15:0] loop_duty_q [NUM_MOTORS];
	logic signed [15:0] applied_q   [NUM_MOTORS];

	logic signed [16:0] corr;
	logic signed [17:0] acc;
	logic signed [15:0] closed_duty;
	logic signed [15:0] duty;
	logic [16:0]        abs_new, abs_other, abs_min;
	freq_sel_t          freq;

	function automatic logic [16:0] abs17(input logic signed [15:0] v);
		logic signed [16:0] w;
		w = 17'(v);
		return v[15] ? 17'(-w) : 17'(w);
	endfunction

	assign en_s10   = !v_s10 || out_ready;
	assign in_ready = en_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s10 <= 1'b0;
		else if (en_s10)
			v_s10 <= in_valid;
	end

	// signed correction onto the held duty, saturated
	always_comb begin
		corr = in_item.neg ? -signed'({1'b0, in_item.mag}) : signed'({1'b0, in_item.mag});
		acc  = 18'(loop_duty_q[in_item.motor]) + 18'(corr);
		if (acc > 18'sd32767)
			closed_duty = 16'sh7fff;
		else if (acc < -18'sd32768)
			closed_duty = 16'sh8000;
		else
			closed_duty = acc[15:0];
		duty = in_item.engage ? closed_duty : signed'(in_item.mag);
	end

	// prescaler from the smaller absolute applied duty of both motors
	always_comb begin
		abs_new   = abs17(duty);
		abs_other = abs17(applied_q[!in_item.motor]);
		abs_min   = (abs_other < abs_new) ? abs_other : abs_new;
		if (abs_min < THR_LOW)
			freq = FREQ_KEEP;
		else if (abs_min < THR_MID)
			freq = FREQ_DIV1024;
		else if (abs_min < THR_HIGH)
			freq = FREQ_DIV256;
		else
			freq = FREQ_DIV64;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				loop_duty_q[i] <= (i == 0) ? DUTY_INIT0 : '0;
				applied_q[i]   <= '0;
			end
		end else if (en_s10 && in_valid) begin
			applied_q[in_item.motor] <= duty;
			if (in_item.engage)
				loop_duty_q[in_item.motor] <= closed_duty;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (en_s10) begin
			res_s10.motor <= in_item.motor;
			res_s10.duty  <= duty;
			res_s10.freq  <= freq;
		end
	end

	assign out_valid = v_s10;
	assign out_res   = res_s10;

endmodule

`default_nettype wire

// ===== rtl/pid_speed_slew_limiter.sv =====
// Top level of the two-motor PID speed controller with slew-rate limited duty.
//
// Input stream: one request per control step. s_tuser[0] picks the motor,
// s_tuser[1] selects closed loop (1) or open loop (0); s_tdata carries the
// reference speed in [15:0] and the measured speed in [31:16].
// Output stream: one result per request, in order. m_tuser is the motor,
// m_tdata[15:0] the signed Q2.14 duty now applied, m_tdata[17:16] the PWM
// prescaler choice.
// Throughput is one request per cycle for any motor mix while m_tready is
// high. The ten-register pipeline: error and integral, gain multiplies, sum,
// bound test, reciprocal multiply in two halves, estimate, remainder
// product, correction, and the final held-duty update with the result
// register. Gains and accel limit are written on cfg_we/cfg_addr/cfg_wdata
// by the user only while the pipeline is empty; the block does not enforce
// it. An accel limit write of zero or above 1.0 is dropped. Reset empties
// the pipeline, loads default gains, clears integrals, last errors and
// applied duties, and sets the held duty of motor 0 to 0.2. A stalled
// receiver holds the result; earlier stages keep filling bubbles, and
// s_tready falls only once every stage is occupied.
`default_nettype none

module pid_speed_slew_limiter #(
	parameter int MAX_SPEED_UNITS = pslim_pkg::MAX_SPEED_UNITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // ref_speed[15:0], curr_speed[31:16]
	input  logic [1:0]  s_tuser,   // motor_sel[0], closed_loop[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // duty_cmd[15:0], freq_sel[17:16], zero fill
	output logic        m_tuser,   // motor_out
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import pslim_pkg::*;

	cfg_t cfg_q;

	logic      err_valid, err_ready;
	err_item_t err_item;
	logic      mac_valid, mac_ready;
	mac_item_t mac_item;
	logic      div_valid, div_ready;
	div_item_t div_item;
	res_t      res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop   <= GAIN_PROP_RESET;
			cfg_q.gain_integ  <= '0;
			cfg_q.gain_deriv  <= '0;
			cfg_q.accel_limit <= ACCEL_RESET;
		end else if (cfg_we) begin
			case (cfg_addr_t'(cfg_addr))
				CFG_GAIN_PROP:   cfg_q.gain_prop  <= cfg_wdata;
				CFG_GAIN_INTEG:  cfg_q.gain_integ <= cfg_wdata;
				CFG_GAIN_DERIV:  cfg_q.gain_deriv <= cfg_wdata;
				CFG_ACCEL_LIMIT: begin
					if (cfg_wdata[14:0] != '0 && cfg_wdata[14:0] <= ACCEL_MAX)
						cfg_q.accel_limit <= cfg_wdata[14:0];
				end
				default: ;
			endcase
		end
	end

	pslim_err u_err (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.motor_sel   (s_tuser[0]),
		.closed_loop (s_tuser[1]),
		.ref_speed   (s_tdata[15:0]),
		.curr_speed  (s_tdata[31:16]),
		.out_valid   (err_valid),
		.out_ready   (err_ready),
		.out_item    (err_item)
	);

	pslim_mac #(
		.MAX_SPEED_UNITS (MAX_SPEED_UNITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (err_valid),
		.in_ready  (err_ready),
		.in_item   (err_item),
		.out_valid (mac_valid),
		.out_ready (mac_ready),
		.out_item  (mac_item)
	);

	pslim_div #(
		.MAX_SPEED_UNITS (MAX_SPEED_UNITS)
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.accel_limit (cfg_q.accel_limit),
		.in_valid    (mac_valid),
		.in_ready    (mac_ready),
		.in_item     (mac_item),
		.out_valid   (div_valid),
		.out_ready   (div_ready),
		.out_item    (div_item)
	);

	pslim_duty u_duty (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_item   (div_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {6'b0, res.freq, res.duty};
	assign m_tuser = res.motor;

endmodule

`default_nettype wire

// ===== rtl/pslim_checker.sv =====
// Port-level checks of the speed controller and their binding to the top level.
`default_nettype none

module pslim_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);
	import pslim_pkg::*;

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

	logic [CNT_W-1:0]   pend_q;
	logic               acc_in, acc_out;
	logic signed [15:0] duty;
	logic [16:0]        duty_abs;

	assign acc_in   = s_tvalid && s_tready;
	assign acc_out  = m_tvalid && m_tready;
	assign duty     = m_tdata[15:0];
	assign duty_abs = duty[15] ? 17'(-(17'(duty))) : 17'(17'(duty));

	// requests inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (acc_in && !acc_out)
			pend_q <= pend_q + 1'b1;
		else if (!acc_in && acc_out)
			pend_q <= pend_q - 1'b1;
	end

	// no result without a request inside
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == '0) |-> !m_tvalid)
		else $error("result shown with no request pending");

	// a draining receiver never backs up the input
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

	// a small duty on this motor forces the smaller of both under the low threshold
	a_freq_low: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && duty_abs < THR_LOW) |-> (m_tdata[17:16] == FREQ_KEEP))
		else $error("prescaler choice above small duty");

endmodule

bind pid_speed_slew_limiter pslim_checker u_pslim_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
